### rtl/vrlr_pkg.sv
// ----------------------------------------------------------------------------
// vrlr_pkg
// Types and constants shared by the variable-rate linear resampler.
// ----------------------------------------------------------------------------
`default_nettype none

package vrlr_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int DIFF_W     = 17;
  localparam int RATE_W     = 17;
  localparam int PHASE_W    = 18;
  localparam int FRAC_W     = 15;
  localparam int PROD_W     = 33;
  localparam int FRAC_SHIFT = 15;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [DIFF_W-1:0]   diff_t;
  typedef logic        [RATE_W-1:0]   rate_t;
  typedef logic        [PHASE_W-1:0]  phase_t;
  typedef logic        [FRAC_W-1:0]   frac_t;
  typedef logic signed [PROD_W-1:0]   prod_t;

  localparam rate_t  RATE_MIN     = 17'd32768;
  localparam rate_t  RATE_MAX     = 17'd98304;
  localparam rate_t  RATE_NEUTRAL = 17'd65536;
  localparam phase_t PHASE_ONE    = 18'd65536;
  localparam phase_t PHASE_LIMIT  = 18'd98304;
  localparam prod_t  TRUNC_ADJ    = 33'sd32767;

  typedef struct packed {
    sample_t prev;
    diff_t   diff;
  } work_t;

  function automatic rate_t clamp_rate(input rate_t value);
    rate_t result;
    result = value;
    if (value < RATE_MIN) begin
      result = RATE_MIN;
    end else if (value > RATE_MAX) begin
      result = RATE_MAX;
    end
    return result;
  endfunction

endpackage

`default_nettype wire

### rtl/vrlr_ifs.sv
// ----------------------------------------------------------------------------
// vrlr_ifs
// Valid/ready channels of the resampler: input samples, output samples and
// the rate register write port.
// ----------------------------------------------------------------------------
`default_nettype none

interface vrlr_in_if;
  logic              valid;
  logic              ready;
  vrlr_pkg::sample_t sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface vrlr_out_if;
  logic              valid;
  logic              ready;
  vrlr_pkg::sample_t sample_out;
  logic              last;
  modport source (output valid, output sample_out, output last, input ready);
  modport sink   (input valid, input sample_out, input last, output ready);
endinterface

interface vrlr_cfg_if;
  logic            valid;
  logic            ready;
  vrlr_pkg::rate_t requested_rate;
  modport source (output valid, output requested_rate, input ready);
  modport sink   (input valid, input requested_rate, output ready);
endinterface

`default_nettype wire

### rtl/vrlr_front.sv
// ----------------------------------------------------------------------------
// vrlr_front
// Accepts input samples, primes on the first one and queues the previous
// sample with the difference to the new one for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module vrlr_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  vrlr_in_if.sink              in_if,
  output vrlr_pkg::work_t      push_data,
  output logic                 push_valid,
  input  wire logic            push_ready
);
  import vrlr_pkg::*;

  sample_t prev_r;
  logic    have_prev_r;
  logic    accept;

  assign in_if.ready = have_prev_r ? push_ready : 1'b1;
  assign accept      = in_if.valid && in_if.ready;
  assign push_valid  = in_if.valid && have_prev_r;

  always_comb begin
    push_data.prev = prev_r;
    push_data.diff = DIFF_W'(in_if.sample_in) - DIFF_W'(prev_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
      prev_r      <= '0;
    end else if (accept) begin
      have_prev_r <= 1'b1;
      prev_r      <= in_if.sample_in;
    end
  end

endmodule

`default_nettype wire

### rtl/vrlr_queue.sv
// ----------------------------------------------------------------------------
// vrlr_queue
// Two-entry queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module vrlr_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  vrlr_pkg::work_t      push_data,
  input  wire logic            push_valid,
  output logic                 push_ready,
  output vrlr_pkg::work_t      pop_data,
  output logic                 pop_valid,
  input  wire logic            pop_ready
);
  import vrlr_pkg::*;

  work_t       entry_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  count_r;
  logic        do_push;
  logic        do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 2'd1;
      end else if (!do_push && do_pop) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

### rtl/vrlr_back.sv
// ----------------------------------------------------------------------------
// vrlr_back
// Phase accumulator, rate slew and interpolation; emits one output sample
// per cycle into the output register while that register is free or being read.
// ----------------------------------------------------------------------------
`default_nettype none

module vrlr_back #(
  parameter int SLEW_STEP = 128
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  vrlr_pkg::work_t      pop_data,
  input  wire logic            pop_valid,
  output logic                 pop_ready,
  vrlr_cfg_if.sink             cfg_if,
  vrlr_out_if.source           out_if
);
  import vrlr_pkg::*;

  localparam logic ST_FIRST  = 1'b0;
  localparam logic ST_SECOND = 1'b1;
  localparam rate_t STEP     = RATE_W'(SLEW_STEP);

  logic    state_r;
  phase_t  phase_r;
  rate_t   cur_rate_r;
  rate_t   req_rate_r;
  logic    out_valid_r;
  sample_t out_sample_r;
  logic    out_last_r;

  logic    out_free;
  logic    below_one;
  logic    fire;
  logic    emit;
  logic    emit_last;
  rate_t   gap;
  rate_t   rate_nxt;
  phase_t  phase_sum;
  phase_t  wrap_src;
  phase_t  phase_wrapped;
  phase_t  phase_nxt;
  frac_t   frac;
  prod_t   prod;
  prod_t   prod_adj;
  prod_t   quot;
  sample_t sample_nxt;

  assign cfg_if.ready = 1'b1;

  assign out_if.valid      = out_valid_r;
  assign out_if.sample_out = out_sample_r;
  assign out_if.last       = out_last_r;

  always_comb begin
    out_free  = !out_valid_r || out_if.ready;
    below_one = (phase_r < PHASE_ONE);
    fire      = pop_valid && (!below_one || out_free);
    emit      = fire && below_one;

    rate_nxt = cur_rate_r;
    gap      = '0;
    if (cur_rate_r < req_rate_r) begin
      gap      = req_rate_r - cur_rate_r;
      rate_nxt = cur_rate_r + ((gap < STEP) ? gap : STEP);
    end else if (cur_rate_r > req_rate_r) begin
      gap      = cur_rate_r - req_rate_r;
      rate_nxt = cur_rate_r - ((gap < STEP) ? gap : STEP);
    end

    phase_sum = phase_r + PHASE_W'(rate_nxt);
    emit_last = (state_r == ST_SECOND) || (phase_sum >= PHASE_ONE);

    wrap_src      = below_one ? phase_sum : phase_r;
    phase_wrapped = (wrap_src >= PHASE_ONE) ? (wrap_src - PHASE_ONE) : '0;
    phase_wrapped = {1'b0, phase_wrapped[PHASE_W-2:0]};

    if (below_one && !emit_last) begin
      phase_nxt = phase_sum;
    end else begin
      phase_nxt = phase_wrapped;
    end

    pop_ready = fire && (!below_one || emit_last);

    frac       = phase_r[FRAC_W:1];
    prod       = PROD_W'(pop_data.diff) * PROD_W'($signed({1'b0, frac}));
    prod_adj   = prod[PROD_W-1] ? (prod + TRUNC_ADJ) : prod;
    quot       = prod_adj >>> FRAC_SHIFT;
    sample_nxt = pop_data.prev + SAMPLE_W'(quot);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FIRST;
      phase_r     <= '0;
      cur_rate_r  <= RATE_NEUTRAL;
      req_rate_r  <= RATE_NEUTRAL;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_if.valid) begin
        req_rate_r <= clamp_rate(cfg_if.requested_rate);
      end
      if (fire) begin
        phase_r <= phase_nxt;
        if (emit) begin
          cur_rate_r <= rate_nxt;
        end
        case (state_r)
          ST_FIRST: begin
            if (emit && !emit_last) begin
              state_r <= ST_SECOND;
            end
          end
          ST_SECOND: begin
            state_r <= ST_FIRST;
          end
          default: begin
            state_r <= ST_FIRST;
          end
        endcase
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_sample_r <= sample_nxt;
      out_last_r   <= emit_last;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (cur_rate_r >= RATE_MIN) && (cur_rate_r <= RATE_MAX))
    else $error("Current rate left the range 0.5 to 1.5.");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIRST) |-> (phase_r < PHASE_LIMIT))
    else $error("Phase between inputs reached 1.5.");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SECOND) |-> (pop_valid && (phase_r < PHASE_ONE)))
    else $error("Second output pending without a queued item below phase 1.0.");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_if.ready) |-> !emit)
    else $error("Output register overwritten while a transfer is pending.");

endmodule

`default_nettype wire

### rtl/variable_rate_linear_resampler.sv
// ----------------------------------------------------------------------------
// variable_rate_linear_resampler
// Linear interpolation resampler with a slewed playback rate.
// ----------------------------------------------------------------------------
// The front end takes one input sample per cycle into a two-entry queue while
// the queue has room; the first sample after reset only primes the block and
// yields no output. The back end takes each queued input in turn, makes up
// to two output samples from it or none, and pops it only when it is through
// with it, so the sustained rate is set by that single interpolation unit.
// Each output is held in the output register. The rate register may be
// written only while no input is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module variable_rate_linear_resampler #(
  parameter int SLEW_STEP = 128
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  vrlr_in_if.sink    in_if,
  vrlr_cfg_if.sink   cfg_if,
  vrlr_out_if.source out_if
);
  import vrlr_pkg::*;

  work_t push_data;
  logic  push_valid;
  logic  push_ready;
  work_t pop_data;
  logic  pop_valid;
  logic  pop_ready;

  vrlr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  vrlr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_data   (pop_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  vrlr_back #(
    .SLEW_STEP (SLEW_STEP)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_data  (pop_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .cfg_if    (cfg_if),
    .out_if    (out_if)
  );

endmodule

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the variable-rate linear resampler.
// ----------------------------------------------------------------------------
// Mono samples are streamed into the block under several requested rates,
// the out-of-range values among them, while both channels stall at random.
// A scoreboard tracks phase, slewed rate and previous sample, predicts each
// interpolated output and its last flag, and compares them as they arrive.
// ----------------------------------------------------------------------------

module tb;
  import vrlr_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int SLEW         = 128;
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_ITEMS = 900;
  localparam int LIMIT_CYCLES = 200_000;

  typedef struct {
    sample_t sample;
    logic    last;
  } out_item_t;

  class resample_scoreboard;
    sample_t     prev_sample;
    bit          primed;
    int unsigned phase;
    int unsigned cur_rate;
    int unsigned target_rate;
    out_item_t   expected_out[$];
    int          mismatches;
    int          n_in;
    int          n_out;
    int          n_silent;
    int          n_writes;

    function new();
      prev_sample = '0;
      primed      = 1'b0;
      phase       = 0;
      cur_rate    = RATE_NEUTRAL;
      target_rate = RATE_NEUTRAL;
      mismatches  = 0;
      n_in        = 0;
      n_out       = 0;
      n_silent    = 0;
      n_writes    = 0;
    endfunction

    function int pending();
      return expected_out.size();
    endfunction

    function void set_rate(rate_t value);
      n_writes++;
      if (value < RATE_MIN) begin
        target_rate = RATE_MIN;
      end else if (value > RATE_MAX) begin
        target_rate = RATE_MAX;
      end else begin
        target_rate = value;
      end
    endfunction

    function void accept_sample(sample_t s);
      int        diff;
      int        frac;
      int        cnt;
      longint    prod;
      out_item_t item[2];
      n_in++;
      if (!primed) begin
        prev_sample = s;
        primed      = 1'b1;
        n_silent++;
        return;
      end
      diff = int'(s) - int'(prev_sample);
      cnt  = 0;
      while (phase < PHASE_ONE && cnt < 2) begin
        frac = int'((phase & 32'hFFFF) >> 1);
        prod = longint'(diff) * longint'(frac);
        item[cnt].sample = sample_t'(int'(prev_sample) + int'(prod / 32768));
        cnt++;
        if (cur_rate < target_rate) begin
          cur_rate += (target_rate - cur_rate < SLEW) ? target_rate - cur_rate : SLEW;
        end else if (cur_rate > target_rate) begin
          cur_rate -= (cur_rate - target_rate < SLEW) ? cur_rate - target_rate : SLEW;
        end
        phase += cur_rate;
      end
      for (int i = 0; i < cnt; i++) begin
        item[i].last = (i == cnt - 1);
        expected_out.push_back(item[i]);
      end
      if (cnt == 0) begin
        n_silent++;
      end
      phase = (phase >= PHASE_ONE) ? phase - PHASE_ONE : 0;
      phase &= 32'h1FFFF;
      prev_sample = s;
    endfunction

    task report(string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task compare_output(sample_t s, logic l);
      out_item_t e;
      n_out++;
      if (expected_out.size() == 0) begin
        report($sformatf("output %0d (last %0b) with none expected", s, l));
        return;
      end
      e = expected_out.pop_front();
      if (s !== e.sample) begin
        report($sformatf("output %0d: sample_out %0d, expected %0d", n_out, s, e.sample));
      end
      if (l !== e.last) begin
        report($sformatf("output %0d: last %0b, expected %0b", n_out, l, e.last));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic quiet;
  sample_t last_sent;
  int sent;
  resample_scoreboard sb;

  vrlr_in_if  in_if ();
  vrlr_cfg_if cfg_if ();
  vrlr_out_if out_if ();

  variable_rate_linear_resampler #(
    .SLEW_STEP(SLEW)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .cfg_if(cfg_if),
    .out_if(out_if)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("Timed out with %0d outputs still expected.", sb.pending());
    $display("variable_rate_linear_resampler verification failed");
    $finish;
  end

  always @(posedge clk) begin
    out_if.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 20);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) begin
        sb.set_rate(cfg_if.requested_rate);
      end
      if (in_if.valid && in_if.ready) begin
        sb.accept_sample(in_if.sample_in);
      end
      if (out_if.valid && out_if.ready) begin
        sb.compare_output(out_if.sample_out, out_if.last);
      end
    end
  end

  task automatic send_sample(input sample_t s);
    while (!quiet && $urandom_range(99) < 20) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.sample_in <= s;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    last_sent = s;
    sent++;
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_rate(input rate_t value);
    cfg_if.valid          <= 1'b1;
    cfg_if.requested_rate <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(9))
      0: return $urandom_range(1) ? sample_t'(16'sh7FFF) : sample_t'(-16'sh8000);
      1: return sample_t'(int'(last_sent) + $signed($urandom_range(64)) - 32);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic rate_t pick_rate();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return RATE_MIN;
      3: return RATE_MAX;
      4: return RATE_NEUTRAL;
      5: return rate_t'($urandom);
      default: return rate_t'($urandom_range(RATE_MAX, RATE_MIN));
    endcase
  endfunction

  task automatic send_batch(input rate_t value, input int count);
    settle();
    write_rate(value);
    repeat (count) send_sample(pick_sample());
  endtask

  initial begin
    sb        = new();
    quiet     = 1'b0;
    last_sent = '0;
    sent      = 0;
    rst_n                 <= 1'b0;
    in_if.valid           <= 1'b0;
    in_if.sample_in       <= '0;
    cfg_if.valid          <= 1'b0;
    cfg_if.requested_rate <= RATE_NEUTRAL;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The first sample only primes the block; the rest run at the reset rate.
    send_sample(16'sh7FFF);
    send_sample(-16'sh8000);
    send_sample(16'sh7FFF);
    send_sample(16'sh0000);
    send_sample(-16'sh0001);
    send_sample(16'sh0001);
    send_sample(-16'sh8000);
    send_sample(-16'sh8000);
    send_sample(16'sh3039);

    // A write below the range clamps to half speed; the rate slews down.
    settle();
    write_rate('0);
    send_sample(16'sh7FFF);
    send_sample(-16'sh8000);
    send_sample(16'sh7FFF);
    send_sample(-16'sh8000);
    send_sample(16'sh0064);
    send_sample(-16'sh0064);

    // A write above the range clamps to 1.5 times speed.
    settle();
    write_rate('1);
    send_sample(16'sh5555);
    send_sample(-16'sh5556);
    send_sample(16'sh7FFF);
    send_sample(-16'sh8000);
    send_sample(16'sh0000);
    send_sample(16'sh7FFF);
    send_sample(-16'sh8000);
    send_sample(16'sh2AAA);

    sent = 0;
    quiet = 1'b1;
    send_batch(RATE_MAX, 250);
    quiet = 1'b0;
    send_batch(RATE_MIN, 200);
    while (sent < RANDOM_ITEMS) begin
      send_batch(pick_rate(), $urandom_range(150, 30));
    end
    settle();

    $display("Streamed %0d samples (%0d gave no output) and checked %0d outputs",
             sb.n_in, sb.n_silent, sb.n_out);
    $display("across %0d rate writes, clamped extremes included.", sb.n_writes);
    if (sb.mismatches == 0) begin
      $display("variable_rate_linear_resampler verification clean");
    end else begin
      $display("variable_rate_linear_resampler verification failed");
    end
    $finish;
  end

endmodule
